### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define RK_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rk4o assertion failed");
// condition must never be seen outside reset
`define RK_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rk4o forbidden condition seen");
`else
`define RK_ASSERT(label, prop)
`define RK_ASSERT_NEVER(label, cond)
`endif

`endif

### sv/rk4o_pkg.sv
// ----------------------------------------------------------------------------
// rk4o_pkg
// Types, constants and tables shared by the RK4 odometry unit.
// ----------------------------------------------------------------------------
package rk4o_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF  = 16;

    localparam int TS_W    = 40;
    localparam int DT_W    = 24;
    localparam int SPEED_W = 16;
    localparam int YAW_W   = 16;
    localparam int OUT_W   = 32;
    localparam int ANG16_W = 16;

    localparam logic [DT_W-1:0] MAX_STEP_RESET = 24'd1000000;

    // round(2^56 / (2*pi*4.096e9))
    localparam logic [21:0] RATE_RECIP = 22'd2799883;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // 1536000000 = 46875 * 2^15
    localparam logic [60:0] DISP_HALF    = 61'd768000000;
    localparam int          DISP_SHIFT   = 15;
    // ceil(2^59 / 46875); (n * DISP_RECIP) >> 59 == n / 46875 for n below 2^43
    localparam logic [43:0] DISP_RECIP    = 44'd12297829382474;
    localparam int          DISP_RECIP_SH = 59;

    localparam int IT_W = 5;   // covers the 24 table entries

    typedef struct packed {
        logic signed [YAW_W-1:0]   yaw_rate;
        logic signed [SPEED_W-1:0] linear_speed;
        logic [DT_W-1:0]           dt;
    } step_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ANG,
        ST_CINIT,
        ST_CITER,
        ST_CDONE,
        ST_DMUL,
        ST_PMUL1,
        ST_PMUL2,
        ST_RINIT,
        ST_RMUL,
        ST_OUT
    } back_state_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic signed [33:0] atan_turn(input logic [IT_W-1:0] i);
        logic signed [33:0] r;
        r = '0;
        case (i)
            5'd0:    r = 34'sd536870912;
            5'd1:    r = 34'sd316933406;
            5'd2:    r = 34'sd167458907;
            5'd3:    r = 34'sd85004756;
            5'd4:    r = 34'sd42667331;
            5'd5:    r = 34'sd21354465;
            5'd6:    r = 34'sd10679838;
            5'd7:    r = 34'sd5340245;
            5'd8:    r = 34'sd2670163;
            5'd9:    r = 34'sd1335087;
            5'd10:   r = 34'sd667544;
            5'd11:   r = 34'sd333772;
            5'd12:   r = 34'sd166886;
            5'd13:   r = 34'sd83443;
            5'd14:   r = 34'sd41722;
            5'd15:   r = 34'sd20861;
            5'd16:   r = 34'sd10430;
            5'd17:   r = 34'sd5215;
            5'd18:   r = 34'sd2608;
            5'd19:   r = 34'sd1304;
            5'd20:   r = 34'sd652;
            5'd21:   r = 34'sd326;
            5'd22:   r = 34'sd163;
            5'd23:   r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/rk4_unicycle_odometry_unit.sv
// ----------------------------------------------------------------------------
// rk4_unicycle_odometry_unit
// RK4 dead reckoning of a unicycle from timestamped speed and yaw-rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per request (timestamp, speed, yaw rate); m_axis
//   returns one result per sample (dx, dy, heading change, new heading).
//   cfg_* writes max_step_time; write it only while no sample is in flight.
//   The front forms the clamped step time and queues the request in a
//   two-entry queue; the back sequencer then runs one request at a time.
//   For each request the back forms the heading increments, runs the shared
//   CORDIC unit for each of the three headings, and does the displacement
//   divide as a reciprocal multiply; it takes the next request from the
//   queue only after the last result has gone into the output register.
//   A result waits in the output register while m_axis_tready is low; the
//   back may finish the next sample up to its output stage, and the front keeps
//   taking samples until the queue fills.
//   Reset clears heading, last timestamp and first-sample flag, and loads
//   max_step_time with 1000000 us.
// ----------------------------------------------------------------------------
module rk4_unicycle_odometry_unit
    import rk4o_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [71:0]     s_axis_tdata,   // timestamp_us, linear_speed, yaw_rate
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [95:0]     m_axis_tdata,   // step_dx, step_dy, step_dtheta, new_heading
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [DT_W-1:0] cfg_data        // max_step_time
);

    q_status_t q_status;
    logic      q_push, q_pop;
    step_req_t push_item, pop_item;

    rk4o_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    rk4o_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    rk4o_back #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### sv/rk4o_front.sv
// ----------------------------------------------------------------------------
// rk4o_front
// Takes samples, holds the step-time register and forms the clamped step time.
// ----------------------------------------------------------------------------
module rk4o_front
    import rk4o_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [71:0]             s_axis_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [DT_W-1:0]         cfg_data,
    input  q_status_t               q_status,
    output logic                    q_push,
    output step_req_t               q_item
);

    logic [TS_W-1:0] last_ts_reg, last_ts_next;
    logic            have_prev_reg, have_prev_next;
    logic [DT_W-1:0] max_step_reg, max_step_next;

    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] gap;
    logic            accept;

    assign ts            = s_axis_tdata[39:0];
    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign gap           = ts - last_ts_reg;

    always_comb
    begin
        q_item.linear_speed = s_axis_tdata[55:40];
        q_item.yaw_rate     = s_axis_tdata[71:56];
        if (!have_prev_reg)
        begin
            q_item.dt = '0;
        end
        else if (gap > {{(TS_W-DT_W){1'b0}}, max_step_reg})
        begin
            q_item.dt = max_step_reg;
        end
        else
        begin
            q_item.dt = gap[DT_W-1:0];
        end
    end

    assign q_push = accept;

    always_comb
    begin
        last_ts_next   = last_ts_reg;
        have_prev_next = have_prev_reg;
        max_step_next  = max_step_reg;
        if (accept)
        begin
            last_ts_next   = ts;
            have_prev_next = 1'b1;
        end
        if (cfg_valid && cfg_ready)
        begin
            max_step_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ts_reg   <= '0;
            have_prev_reg <= 1'b0;
            max_step_reg  <= MAX_STEP_RESET;
        end
        else
        begin
            last_ts_reg   <= last_ts_next;
            have_prev_reg <= have_prev_next;
            max_step_reg  <= max_step_next;
        end
    end

endmodule

### sv/rk4o_fifo.sv
// ----------------------------------------------------------------------------
// rk4o_fifo
// Two-entry request queue between the front and the integrator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rk4o_fifo
    import rk4o_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_req_t push_item,
    input  logic      pop,
    output step_req_t pop_item,
    output q_status_t status
);

    step_req_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RK_ASSERT_NEVER(a_fifo_overflow, push && status.full && !pop)
    `RK_ASSERT_NEVER(a_fifo_underflow, pop && status.empty)
    `RK_ASSERT(a_fifo_ptrs, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))

endmodule

### sv/rk4o_back.sv
// ----------------------------------------------------------------------------
// rk4o_back
// Sequenced RK4 integrator: heading increments, shared CORDIC, displacement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rk4o_back
    import rk4o_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_status,
    input  step_req_t   q_item,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata
);

    localparam int FULL_SH = 56 - ANGLE_BITS;
    localparam int HALF_SH = 57 - ANGLE_BITS;
    localparam int D16_SH  = 40;
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(TRIG_ITERATIONS - 1);

    back_state_t state_reg, state_next;

    logic [DT_W-1:0]              dt_reg;
    logic signed [SPEED_W-1:0]    speed_reg;
    logic signed [YAW_W-1:0]      yaw_reg;
    logic                         wneg_reg;
    logic [39:0]                  p1_reg;
    logic [61:0]                  mag_reg;
    logic [ANGLE_BITS-1:0]        heading_reg;
    logic [ANGLE_BITS-1:0]        hmid_reg, hend_reg;
    logic [15:0]                  d16_reg;
    logic [1:0]                   phase_reg;
    logic [IT_W-1:0]              iter_reg;
    logic signed [33:0]           x_reg, y_reg, ang_reg;
    logic                         flip_reg;
    logic signed [21:0]           csum_reg, ssum_reg;
    logic                         xneg_reg, yneg_reg;
    logic [35:0]                  smx_reg, smy_reg;
    logic [59:0]                  px_reg, py_reg;
    logic [42:0]                  nx_reg, ny_reg;
    logic [86:0]                  accx_reg, accy_reg;
    logic [1:0]                   rm_cnt_reg;
    logic                         out_valid_reg;
    logic [95:0]                  out_data_reg;

    logic load_out;

    // -------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (!q_status.empty) state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_MUL3;
            ST_MUL3:    state_next = ST_ANG;
            ST_ANG:     state_next = ST_CINIT;
            ST_CINIT:   state_next = ST_CITER;
            ST_CITER:   if (iter_reg == LAST_IT) state_next = ST_CDONE;
            ST_CDONE:   state_next = (phase_reg == 2'd2) ? ST_DMUL : ST_CINIT;
            ST_DMUL:    state_next = ST_PMUL1;
            ST_PMUL1:   state_next = ST_PMUL2;
            ST_PMUL2:   state_next = ST_RINIT;
            ST_RINIT:   state_next = ST_RMUL;
            ST_RMUL:    if (rm_cnt_reg == 2'd3) state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop    = !q_status.empty;
            ST_OUT:  load_out = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    // ------------------------------------------------------ combinational math
    logic [15:0]            yaw_mag;
    logic [62:0]            full_r, half_r, d16_r;
    logic [ANGLE_BITS-1:0]  full_inc, half_inc;
    logic [15:0]            d16_val;
    logic [ANGLE_BITS-1:0]  cin_angle;
    logic [31:0]            turn32;
    logic signed [33:0]     ang_ext, ang_fold;
    logic                   fold_flip;
    logic signed [33:0]     atan_i;
    logic signed [33:0]     xf, yf, xr, yr;
    logic signed [19:0]     cval, sval;
    logic signed [37:0]     sx_prod, sy_prod;
    logic [37:0]            sx_abs, sy_abs;
    logic [60:0]            nx_sum, ny_sum;
    logic [21:0]            rm_ax, rm_ay, rm_m;
    logic [43:0]            ppx, ppy;
    logic [86:0]            ppx_sh, ppy_sh;
    logic [31:0]            dx_mag, dy_mag, dx_val, dy_val;
    logic [ANGLE_BITS+15:0] head_pad;

    assign yaw_mag = yaw_reg[YAW_W-1] ? 16'(-yaw_reg) : 16'(yaw_reg);
    assign full_r  = ({1'b0, mag_reg} + (63'd1 << (FULL_SH - 1))) >> FULL_SH;
    assign half_r  = ({1'b0, mag_reg} + (63'd1 << (HALF_SH - 1))) >> HALF_SH;
    assign d16_r   = ({1'b0, mag_reg} + (63'd1 << (D16_SH - 1))) >> D16_SH;
    assign full_inc = wneg_reg ? -full_r[ANGLE_BITS-1:0] : full_r[ANGLE_BITS-1:0];
    assign half_inc = wneg_reg ? -half_r[ANGLE_BITS-1:0] : half_r[ANGLE_BITS-1:0];
    assign d16_val  = wneg_reg ? -d16_r[15:0] : d16_r[15:0];

    always_comb
    begin
        case (phase_reg)
            2'd0:    cin_angle = heading_reg;
            2'd1:    cin_angle = hmid_reg;
            default: cin_angle = hend_reg;
        endcase
    end

    // fold into +-quarter turn, negate the result afterwards
    assign turn32  = {cin_angle, {(32-ANGLE_BITS){1'b0}}};
    assign ang_ext = {{2{turn32[31]}}, turn32};
    always_comb
    begin
        ang_fold  = ang_ext;
        fold_flip = 1'b0;
        if (ang_ext > 34'sd1073741824)
        begin
            ang_fold  = ang_ext - 34'sd2147483648;
            fold_flip = 1'b1;
        end
        else if (ang_ext < -34'sd1073741824)
        begin
            ang_fold  = ang_ext + 34'sd2147483648;
            fold_flip = 1'b1;
        end
    end

    assign atan_i = atan_turn(iter_reg);
    assign xf     = flip_reg ? -x_reg : x_reg;
    assign yf     = flip_reg ? -y_reg : y_reg;
    assign xr     = (xf + 34'sd8192) >>> 14;
    assign yr     = (yf + 34'sd8192) >>> 14;
    assign cval   = xr[19:0];
    assign sval   = yr[19:0];

    assign sx_prod = speed_reg * csum_reg;
    assign sy_prod = speed_reg * ssum_reg;
    assign sx_abs  = sx_prod[37] ? 38'(-sx_prod) : 38'(sx_prod);
    assign sy_abs  = sy_prod[37] ? 38'(-sy_prod) : 38'(sy_prod);

    assign nx_sum = {1'b0, px_reg} + DISP_HALF;
    assign ny_sum = {1'b0, py_reg} + DISP_HALF;

    // divide by 46875 as a reciprocal multiply, one 22x22 partial product a cycle:
    // lo*lo, lo*hi, hi*lo, hi*hi
    assign rm_ax = rm_cnt_reg[1] ? {1'b0, nx_reg[42:22]} : nx_reg[21:0];
    assign rm_ay = rm_cnt_reg[1] ? {1'b0, ny_reg[42:22]} : ny_reg[21:0];
    assign rm_m  = rm_cnt_reg[0] ? DISP_RECIP[43:22] : DISP_RECIP[21:0];
    assign ppx   = {22'd0, rm_ax} * {22'd0, rm_m};
    assign ppy   = {22'd0, rm_ay} * {22'd0, rm_m};

    always_comb
    begin
        case (rm_cnt_reg)
            2'd0:
            begin
                ppx_sh = {43'd0, ppx};
                ppy_sh = {43'd0, ppy};
            end
            2'd3:
            begin
                ppx_sh = {ppx[42:0], 44'd0};
                ppy_sh = {ppy[42:0], 44'd0};
            end
            default:
            begin
                ppx_sh = {21'd0, ppx, 22'd0};
                ppy_sh = {21'd0, ppy, 22'd0};
            end
        endcase
    end

    // |S*dt| stays below 2^58, so the quotient is under 2^28 and never saturates
    assign dx_mag   = {4'd0, accx_reg[86:DISP_RECIP_SH]};
    assign dy_mag   = {4'd0, accy_reg[86:DISP_RECIP_SH]};
    assign dx_val   = xneg_reg ? -dx_mag : dx_mag;
    assign dy_val   = yneg_reg ? -dy_mag : dy_mag;
    assign head_pad = {hend_reg, 16'd0};

    // ------------------------------------------------------------ datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dt_reg    <= q_item.dt;
                speed_reg <= q_item.linear_speed;
                yaw_reg   <= q_item.yaw_rate;
            end
            ST_MUL1:
            begin
                // omega is the negated yaw rate
                wneg_reg <= !yaw_reg[YAW_W-1] && (yaw_reg != '0);
                p1_reg   <= yaw_mag * dt_reg;
            end
            ST_MUL2:
            begin
                mag_reg <= {20'd0, {22'd0, p1_reg[19:0]} * {20'd0, RATE_RECIP}};
            end
            ST_MUL3:
            begin
                mag_reg <= mag_reg + {{22'd0, p1_reg[39:20]} * {20'd0, RATE_RECIP}, 20'd0};
            end
            ST_ANG:
            begin
                hmid_reg  <= heading_reg + half_inc;
                hend_reg  <= heading_reg + full_inc;
                d16_reg   <= d16_val;
                phase_reg <= 2'd0;
                csum_reg  <= '0;
                ssum_reg  <= '0;
            end
            ST_CINIT:
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                ang_reg  <= ang_fold;
                flip_reg <= fold_flip;
                iter_reg <= '0;
            end
            ST_CITER:
            begin
                if (ang_reg >= 0)
                begin
                    x_reg   <= x_reg - (y_reg >>> iter_reg);
                    y_reg   <= y_reg + (x_reg >>> iter_reg);
                    ang_reg <= ang_reg - atan_i;
                end
                else
                begin
                    x_reg   <= x_reg + (y_reg >>> iter_reg);
                    y_reg   <= y_reg - (x_reg >>> iter_reg);
                    ang_reg <= ang_reg + atan_i;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            ST_CDONE:
            begin
                // midpoint carries weight 4 (two RK stages)
                if (phase_reg == 2'd1)
                begin
                    csum_reg <= csum_reg + (22'(cval) <<< 2);
                    ssum_reg <= ssum_reg + (22'(sval) <<< 2);
                end
                else
                begin
                    csum_reg <= csum_reg + 22'(cval);
                    ssum_reg <= ssum_reg + 22'(sval);
                end
                phase_reg <= phase_reg + 2'd1;
            end
            ST_DMUL:
            begin
                xneg_reg <= sx_prod[37];
                yneg_reg <= sy_prod[37];
                smx_reg  <= sx_abs[35:0];
                smy_reg  <= sy_abs[35:0];
            end
            ST_PMUL1:
            begin
                px_reg <= {18'd0, {24'd0, smx_reg[17:0]} * {18'd0, dt_reg}};
                py_reg <= {18'd0, {24'd0, smy_reg[17:0]} * {18'd0, dt_reg}};
            end
            ST_PMUL2:
            begin
                px_reg <= px_reg + {{24'd0, smx_reg[35:18]} * {18'd0, dt_reg}, 18'd0};
                py_reg <= py_reg + {{24'd0, smy_reg[35:18]} * {18'd0, dt_reg}, 18'd0};
            end
            ST_RINIT:
            begin
                nx_reg     <= nx_sum[57:DISP_SHIFT];
                ny_reg     <= ny_sum[57:DISP_SHIFT];
                accx_reg   <= '0;
                accy_reg   <= '0;
                rm_cnt_reg <= '0;
            end
            ST_RMUL:
            begin
                accx_reg   <= accx_reg + ppx_sh;
                accy_reg   <= accy_reg + ppy_sh;
                rm_cnt_reg <= rm_cnt_reg + 2'd1;
            end
            default: ;
        endcase
        if (load_out)
        begin
            out_data_reg <= {head_pad[ANGLE_BITS+15 -: 16], d16_reg, dy_val, dx_val};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                heading_reg   <= hend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `RK_ASSERT(a_pop_in_idle, q_pop |-> (state_reg == ST_IDLE))
    `RK_ASSERT(a_load_needs_room, load_out |-> (!out_valid_reg || m_axis_tready))
    `RK_ASSERT(a_iter_bound, (state_reg == ST_CITER) |-> (iter_reg <= LAST_IT))
    `RK_ASSERT(a_phase_bound, (state_reg == ST_CINIT) |-> (phase_reg != 2'd3))

endmodule

### tb/sv/rk4_unicycle_odometry_unit_test.sv
// ----------------------------------------------------------------------------
// rk4_unicycle_odometry_unit_test
// Self-checking bench for the RK4 unicycle odometry unit: samples go in on
// s_axis, a bit-exact predictor of the RK4 step (CORDIC trig, rounding and
// saturation included) builds the expected results and every m_axis result
// is compared field by field, under random stalls and several max_step_time
// settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rk4_unicycle_odometry_unit_test;

    typedef struct packed {
        logic [15:0]        heading;
        logic signed [15:0] dtheta;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
    } odo_result_t;

    class odometry_scoreboard;
        logic [15:0]  heading;
        logic [39:0]  last_ts;
        bit           have_prev;
        logic [23:0]  max_step;
        odo_result_t  pending[$];
        int           errors;
        int           checked;
        longint       atan_tab[24];

        function new();
            longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                163, 81};
            atan_tab = t;
            heading = '0;
            last_ts = '0;
            have_prev = 0;
            max_step = 24'd1000000;
            errors = 0;
            checked = 0;
        endfunction

        function void set_max_step(logic [23:0] v);
            max_step = v;
        endfunction

        function longint round_mag(bit neg, longint mag, int s);
            longint r;
            r = (mag + (64'sd1 <<< (s - 1))) >>> s;
            return neg ? -r : r;
        endfunction

        // rotation-mode CORDIC on a 32-bit turn angle, results rounded to Q16
        function void trig(logic [31:0] a, output longint c, output longint s);
            longint ang, x, y, nx;
            bit flip;
            ang = longint'($signed(a));
            x = 652032874;
            y = 0;
            flip = 0;
            if (ang > 64'sd1073741824)
            begin
                ang -= 64'sd2147483648;
                flip = 1;
            end
            else if (ang < -64'sd1073741824)
            begin
                ang += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < 16; i++)
            begin
                if (ang >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    ang -= atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    ang += atan_tab[i];
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = (x + 8192) >>> 14;
            s = (y + 8192) >>> 14;
        endfunction

        function logic [31:0] travel(longint sum, longint dt);
            bit neg;
            longint q;
            neg = sum < 0;
            q = ((neg ? -sum : sum) * dt + 64'sd768000000) / 64'sd1536000000;
            if (q > 64'sd2147483647)
                q = neg ? 64'sd2147483648 : 64'sd2147483647;
            return neg ? 32'(-q) : 32'(q);
        endfunction

        function void note_sample(logic [39:0] ts, logic signed [15:0] speed,
                                  logic signed [15:0] yaw);
            longint dt, omega, mag, full, half, d16, v;
            longint c0, s0, cm, sm, ce, se;
            logic [39:0] gap;
            logic [15:0] hmid, hend;
            bit neg;
            odo_result_t r;
            dt = 0;
            if (have_prev)
            begin
                gap = ts - last_ts;
                dt = (gap > {16'd0, max_step}) ? longint'(max_step) : longint'(gap);
            end
            last_ts = ts;
            have_prev = 1;
            omega = -longint'(yaw);
            neg = omega < 0;
            mag = (neg ? -omega : omega) * dt * 64'sd2799883;
            full = round_mag(neg, mag, 40);
            half = round_mag(neg, mag, 41);
            d16 = round_mag(neg, mag, 40);
            hmid = heading + 16'(half);
            hend = heading + 16'(full);
            trig({heading, 16'h0}, c0, s0);
            trig({hmid, 16'h0}, cm, sm);
            trig({hend, 16'h0}, ce, se);
            v = longint'(speed);
            heading = hend;
            r.dx = travel(v * c0 + 4 * v * cm + v * ce, dt);
            r.dy = travel(v * s0 + 4 * v * sm + v * se, dt);
            r.dtheta = 16'(d16);
            r.heading = hend;
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %0s: got %0d expected %0d (result %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_result(logic [95:0] data);
            odo_result_t got, want;
            got = data;
            if (pending.size() == 0)
            begin
                report("result with none pending", longint'(got.dx), 0);
            end
            else
            begin
                want = pending.pop_front();
                if (got.dx !== want.dx) report("step_dx", got.dx, want.dx);
                if (got.dy !== want.dy) report("step_dy", got.dy, want.dy);
                if (got.dtheta !== want.dtheta)
                    report("step_dtheta", got.dtheta, want.dtheta);
                if (got.heading !== want.heading)
                    report("new_heading", got.heading, want.heading);
            end
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // timestamp_us, linear_speed, yaw_rate
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;    // step_dx, step_dy, step_dtheta, new_heading
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;

    odometry_scoreboard odo;
    bit          no_gaps;
    bit          hold_request;
    longint      cycles;
    logic [39:0] ts_now;
    int          sent;

    rk4_unicycle_odometry_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("Timeout waiting for results");
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off when asked
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
                hold_request = 0;
            end
            else
                m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            odo.check_result(m_axis_tdata);

    task send_sample(logic [39:0] ts, logic signed [15:0] speed,
                     logic signed [15:0] yaw);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {yaw, speed, ts};
        do @(posedge clk); while (!s_axis_tready);
        odo.note_sample(ts, speed, yaw);
        sent++;
        if (!no_gaps && $urandom_range(0, 99) < 22)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // wait for the unit to drain, then write max_step_time
    task write_max_step(logic [23:0] v);
        s_axis_tvalid <= 0;
        while (odo.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        odo.set_max_step(v);
    endtask

    task random_samples(int count, int max_gap);
        logic [39:0] r40;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            r40 = {$urandom, $urandom};
            if (pick < 80)
                ts_now += $urandom_range(0, max_gap);
            else if (pick < 90)
                ts_now += $urandom_range(0, 24'hFFFFFF + 5000);
            else if (pick < 95)
                ts_now = r40;
            else
                ts_now -= $urandom_range(1, 100000);
            send_sample(ts_now, 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        odo = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_valid = 0;
        cfg_data = '0;
        no_gaps = 0;
        hold_request = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset value of max_step_time: first sample, extremes, gaps
        send_sample(40'd1000, 16'sd256, 16'sd0);
        send_sample(40'd21000, 16'sd256, 16'sd0);
        send_sample(40'd41000, 16'sd32767, 16'sd32767);
        send_sample(40'd61000, -16'sd32768, -16'sd32768);
        send_sample(40'd81000, -16'sd32768, 16'sd32767);
        send_sample(40'd101000, 16'sd0, -16'sd32768);
        send_sample(40'd5000000, 16'sd1000, 16'sd4096);          // long gap
        send_sample(40'd100, -16'sd500, -16'sd4096);             // time runs backwards
        send_sample(40'd100, 16'sd300, 16'sd1000);               // zero gap
        send_sample(40'hFF_FFFF_FFFF, 16'sd32767, -16'sd32768);
        send_sample(40'd0, 16'sd32767, 16'sd32767);              // wraps to a gap of one

        write_max_step(24'd1);
        send_sample(40'd50, 16'sd32767, 16'sd32767);
        send_sample(40'd900000, -16'sd32768, -16'sd32768);
        send_sample(40'd900001, 16'sd12345, -16'sd321);

        // largest step: big turns alias step_dtheta
        write_max_step(24'hFFFFFF);
        send_sample(40'd20000000, 16'sd32767, 16'sd32767);
        send_sample(40'd40000000, -16'sd32768, 16'sd32767);
        send_sample(40'd56777215, 16'sd32767, -16'sd32768);
        send_sample(40'd57000000, -16'sd7, 16'sd5000);
        send_sample(40'd10, 16'sd32767, 16'sd1);
        ts_now = 40'd10;

        write_max_step(24'd1000000);
        hold_request = 1;                 // receiver stops, input fills up
        random_samples(250, 40000);
        write_max_step(24'($urandom_range(1, 24'hFFFFFF)));
        no_gaps = 1;
        random_samples(250, 400000);
        no_gaps = 0;
        write_max_step(24'd20000);
        random_samples(250, 30000);
        write_max_step(24'hFFFFFF);
        random_samples(250, 24'hFFFFFF);

        s_axis_tvalid <= 0;
        while (odo.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Ran %0d samples, %0d results checked, over five max_step_time settings",
                 sent, odo.checked);
        $display("with first-sample, backward, wrapping and clamped gaps and full-scale inputs");
        if (odo.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
